/* hdl/npcd_pkg.sv */
// ----------------------------------------------------------------------------
// npcd_pkg
// Shared types and constants of the nearest palette colour decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package npcd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int IDX_XW        = (IDX_W > 8) ? IDX_W : 8;

    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int DIST_W  = 18;
    localparam int VAL_W   = 40;
    localparam int REG_W   = 32;
    localparam int PROD_W  = IDX_W + REG_W + 1;
    localparam int SUM_W   = (PROD_W + 1 > VAL_W + 1) ? PROD_W + 1 : VAL_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes on the input port
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DECODE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DECODE_ENABLED  = 2'd0;
    localparam logic [1:0] CFG_VALUE_MINIMUM   = 2'd1;
    localparam logic [1:0] CFG_VALUE_INCREMENT = 2'd2;

    localparam logic signed [REG_W-1:0] INCREMENT_RESET = 32'sd256;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_DECODE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pix;

    typedef struct packed {
        t_op  op;
        t_pix pix;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic                    decode_enabled;
        logic signed [REG_W-1:0] value_minimum;
        logic signed [REG_W-1:0] value_increment;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_SUM
    } t_state;

endpackage

`default_nettype wire

/* hdl/npcd_ram.sv */
// ----------------------------------------------------------------------------
// npcd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/npcd_front.sv */
// ----------------------------------------------------------------------------
// npcd_front
// Command intake: handshake, command classification, queue push.
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_front (
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_command,
    input  wire logic [npcd_pkg::CHAN_W-1:0] i_red,
    input  wire logic [npcd_pkg::CHAN_W-1:0] i_green,
    input  wire logic [npcd_pkg::CHAN_W-1:0] i_blue,
    input  wire npcd_pkg::t_qstat            i_qstat,
    output logic                             o_push,
    output npcd_pkg::t_item                  o_item
);

    logic s_accept;
    logic s_known;

    assign s_accept = start && !i_qstat.full;
    assign busy     = i_qstat.full;

    always_comb begin
        s_known          = 1'b1;
        o_item.op        = npcd_pkg::OP_APPEND;
        o_item.pix.red   = i_red;
        o_item.pix.green = i_green;
        o_item.pix.blue  = i_blue;
        unique case (i_command)
            npcd_pkg::CMD_APPEND: o_item.op = npcd_pkg::OP_APPEND;
            npcd_pkg::CMD_DECODE: o_item.op = npcd_pkg::OP_DECODE;
            npcd_pkg::CMD_CLEAR:  o_item.op = npcd_pkg::OP_CLEAR;
            npcd_pkg::CMD_UNUSED: s_known   = 1'b0;
        endcase
    end

    // unused command code is taken and dropped
    assign o_push = s_accept && s_known;

endmodule

`default_nettype wire

/* hdl/npcd_queue.sv */
// ----------------------------------------------------------------------------
// npcd_queue
// Short FIFO of classified items between intake and palette engine.
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire npcd_pkg::t_item i_item,
    input  wire logic            i_pop,
    output npcd_pkg::t_item      o_item,
    output npcd_pkg::t_qstat     o_qstat
);

    npcd_pkg::t_item                  r_entry [npcd_pkg::QUEUE_DEPTH];
    logic [npcd_pkg::QPTR_W-1:0]      r_wptr;
    logic [npcd_pkg::QPTR_W-1:0]      r_rptr;
    logic [npcd_pkg::QCNT_W-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_item        = r_entry[r_rptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == npcd_pkg::QCNT_W'(npcd_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

/* hdl/npcd_back.sv */
// ----------------------------------------------------------------------------
// npcd_back
// Palette engine: owns the palette RAM, runs appends and clears, scans the
// palette for the nearest colour and forms the decoded value.
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire npcd_pkg::t_cfg                   i_cfg,
    input  wire npcd_pkg::t_qstat                 i_qstat,
    input  wire npcd_pkg::t_item                  i_item,
    output logic                                  o_pop,
    output logic                                  o_valid,
    output logic [7:0]                            o_palette_index,
    output logic [npcd_pkg::DIST_W-1:0]           o_colour_distance,
    output logic signed [npcd_pkg::VAL_W-1:0]     o_decoded_value
);

    localparam int IDX_W  = npcd_pkg::IDX_W;
    localparam int CNT_W  = npcd_pkg::CNT_W;
    localparam int DIST_W = npcd_pkg::DIST_W;
    localparam int VAL_W  = npcd_pkg::VAL_W;
    localparam int PROD_W = npcd_pkg::PROD_W;
    localparam int SUM_W  = npcd_pkg::SUM_W;

    localparam logic signed [SUM_W-1:0] SUM_VMAX =
        {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_VMIN =
        {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    function automatic logic [DIST_W-1:0] colour_dist(npcd_pkg::t_pix a,
                                                      npcd_pkg::t_pix b);
        logic signed [8:0]  dr, dg, db;
        logic signed [17:0] sr, sg, sb;
        dr = $signed({1'b0, a.red})   - $signed({1'b0, b.red});
        dg = $signed({1'b0, a.green}) - $signed({1'b0, b.green});
        db = $signed({1'b0, a.blue})  - $signed({1'b0, b.blue});
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        return DIST_W'($unsigned(sr) + $unsigned(sg) + $unsigned(sb));
    endfunction

    npcd_pkg::t_state         r_state, n_state;
    logic [CNT_W-1:0]         r_count;
    npcd_pkg::t_pix           r_pix;
    logic [IDX_W-1:0]         r_addr;
    logic                     r_v1, r_v2;
    logic [IDX_W-1:0]         r_idx1, r_idx2;
    logic [DIST_W-1:0]        r_dist2;
    logic                     r_found;
    logic [IDX_W-1:0]         r_best_idx;
    logic [DIST_W-1:0]        r_best_dist;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    logic [7:0]               r_out_idx;
    logic [DIST_W-1:0]        r_out_dist;
    logic signed [VAL_W-1:0]  r_out_value;

    logic                     s_issue;
    logic                     s_last;
    logic                     s_we;
    logic [npcd_pkg::PIX_W-1:0] s_rdata;
    logic signed [PROD_W-1:0] s_mul_a, s_mul_b;
    logic signed [SUM_W-1:0]  s_sum;
    logic [npcd_pkg::IDX_XW-1:0] s_idx_x;

    npcd_ram #(
        .WIDTH (npcd_pkg::PIX_W),
        .DEPTH (npcd_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_item.pix),
        .i_raddr (r_addr),
        .o_rdata (s_rdata)
    );

    assign s_last = (r_addr == IDX_W'(r_count - 1'b1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npcd_pkg::ST_IDLE: begin
                if (!i_qstat.empty && i_item.op == npcd_pkg::OP_DECODE
                    && i_cfg.decode_enabled) begin
                    n_state = (r_count == '0) ? npcd_pkg::ST_MUL : npcd_pkg::ST_SCAN;
                end
            end
            npcd_pkg::ST_SCAN: begin
                if (s_last) begin
                    n_state = npcd_pkg::ST_DRAIN;
                end
            end
            npcd_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = npcd_pkg::ST_MUL;
                end
            end
            npcd_pkg::ST_MUL: n_state = npcd_pkg::ST_SUM;
            npcd_pkg::ST_SUM: n_state = npcd_pkg::ST_IDLE;
            default:          n_state = npcd_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop   = 1'b0;
        s_issue = 1'b0;
        unique case (r_state)
            npcd_pkg::ST_IDLE:  o_pop   = !i_qstat.empty;
            npcd_pkg::ST_SCAN:  s_issue = 1'b1;
            npcd_pkg::ST_DRAIN,
            npcd_pkg::ST_MUL,
            npcd_pkg::ST_SUM:   ;
            default:            ;
        endcase
    end

    assign s_we = o_pop && (i_item.op == npcd_pkg::OP_APPEND)
                  && (r_count < CNT_W'(npcd_pkg::PALETTE_DEPTH));

    assign s_mul_a = PROD_W'($signed({1'b0, r_best_idx}));
    assign s_mul_b = PROD_W'(i_cfg.value_increment);
    assign s_sum   = SUM_W'(r_prod) + SUM_W'(i_cfg.value_minimum);
    assign s_idx_x = npcd_pkg::IDX_XW'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npcd_pkg::ST_IDLE;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v1        <= s_issue;
            r_v2        <= r_v1;
            r_out_valid <= 1'b0;
            if (o_pop) begin
                unique case (i_item.op)
                    npcd_pkg::OP_APPEND: begin
                        if (s_we) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    npcd_pkg::OP_CLEAR:  r_count <= '0;
                    npcd_pkg::OP_DECODE: begin
                        if (!i_cfg.decode_enabled) begin
                            r_out_valid <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == npcd_pkg::ST_SUM) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.op == npcd_pkg::OP_DECODE) begin
            r_pix       <= i_item.pix;
            r_addr      <= '0;
            r_found     <= 1'b0;
            r_best_idx  <= '0;
            r_best_dist <= '0;
            // red channel mode
            r_out_idx   <= '0;
            r_out_dist  <= '0;
            r_out_value <= VAL_W'({i_item.pix.red, 8'h00});
        end
        if (s_issue && !s_last) begin
            r_addr <= r_addr + 1'b1;
        end
        r_idx1  <= r_addr;
        r_idx2  <= r_idx1;
        r_dist2 <= colour_dist(s_rdata, r_pix);
        // strict less-than keeps the first index on a tie
        if (r_v2 && (!r_found || r_dist2 < r_best_dist)) begin
            r_found     <= 1'b1;
            r_best_idx  <= r_idx2;
            r_best_dist <= r_dist2;
        end
        if (r_state == npcd_pkg::ST_MUL) begin
            r_prod <= s_mul_a * s_mul_b;
        end
        if (r_state == npcd_pkg::ST_SUM) begin
            r_out_idx  <= s_idx_x[7:0];
            r_out_dist <= r_best_dist;
            priority if (s_sum > SUM_VMAX) begin
                r_out_value <= SUM_VMAX[VAL_W-1:0];
            end else if (s_sum < SUM_VMIN) begin
                r_out_value <= SUM_VMIN[VAL_W-1:0];
            end else begin
                r_out_value <= s_sum[VAL_W-1:0];
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_palette_index   = r_out_idx;
    assign o_colour_distance = r_out_dist;
    assign o_decoded_value   = r_out_value;

endmodule

`default_nettype wire

/* hdl/nearest_palette_colour_decoder.sv */
// ----------------------------------------------------------------------------
// nearest_palette_colour_decoder
// Palette of RGB colours with nearest-colour search and signed Q32.8 value decode.
// ----------------------------------------------------------------------------
// Commands enter on start/busy and pass through a two-item queue to the palette
// engine, which takes the next command only once it is idle again. For a decode
// with decoding enabled, the palette RAM has one read port and the scan reads
// one entry per cycle, then a multiply and an add/saturate stage form the value.
// An empty palette skips the scan. busy rises only when the queue is full. Each
// decode gives one result on o_valid for a single cycle; the receiver cannot
// stall it. Configuration writes are always ready and must only be made while
// no decode is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_colour_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_command,
    input  wire logic [7:0]                          i_red,
    input  wire logic [7:0]                          i_green,
    input  wire logic [7:0]                          i_blue,
    output logic                                     o_valid,
    output logic [7:0]                               o_palette_index,
    output logic [npcd_pkg::DIST_W-1:0]              o_colour_distance,
    output logic signed [npcd_pkg::VAL_W-1:0]        o_decoded_value,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic [npcd_pkg::REG_W-1:0]          i_cfg_data
);

    npcd_pkg::t_cfg   r_cfg;
    npcd_pkg::t_qstat s_qstat;
    npcd_pkg::t_item  s_push_item;
    npcd_pkg::t_item  s_head_item;
    logic             s_push;
    logic             s_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_enabled  <= 1'b0;
            r_cfg.value_minimum   <= '0;
            r_cfg.value_increment <= npcd_pkg::INCREMENT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                npcd_pkg::CFG_DECODE_ENABLED:  r_cfg.decode_enabled  <= i_cfg_data[0];
                npcd_pkg::CFG_VALUE_MINIMUM:   r_cfg.value_minimum   <= i_cfg_data;
                npcd_pkg::CFG_VALUE_INCREMENT: r_cfg.value_increment <= i_cfg_data;
                default: ;
            endcase
        end
    end

    npcd_front u_front (
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .i_qstat   (s_qstat),
        .o_push    (s_push),
        .o_item    (s_push_item)
    );

    npcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_item  (s_push_item),
        .i_pop   (s_pop),
        .o_item  (s_head_item),
        .o_qstat (s_qstat)
    );

    npcd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_qstat           (s_qstat),
        .i_item            (s_head_item),
        .o_pop             (s_pop),
        .o_valid           (o_valid),
        .o_palette_index   (o_palette_index),
        .o_colour_distance (o_colour_distance),
        .o_decoded_value   (o_decoded_value)
    );

endmodule

`default_nettype wire

/* hdl/npcd_checker.sv */
// ----------------------------------------------------------------------------
// npcd_port_props
// Port-level assertions for the nearest palette colour decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_port_props (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic [1:0]                     i_command,
    input wire logic [7:0]                     i_red,
    input wire logic [7:0]                     i_green,
    input wire logic [7:0]                     i_blue,
    input wire logic                           o_valid,
    input wire logic [7:0]                     o_palette_index,
    input wire logic [npcd_pkg::DIST_W-1:0]    o_colour_distance,
    input wire logic [npcd_pkg::VAL_W-1:0]     o_decoded_value,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [1:0]                     i_cfg_index,
    input wire logic [npcd_pkg::REG_W-1:0]     i_cfg_data
);

    // reset leaves no result pending and the queue empty
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("result or busy right after reset");

    // three channels of at most 255 each bound the squared distance
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_colour_distance <= 18'd195075))
        else $error("colour distance out of range");

    // the queue only fills on an item taken the cycle before
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind nearest_palette_colour_decoder npcd_port_props u_npcd_port_props (.*);

`default_nettype wire
